// ===== hdl/rse_pkg.sv =====
// Shared types, constants and microcode word layout for the RPN stack evaluator.
`timescale 1ns / 1ps

package rse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int CW          = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int OPC_W       = 3;
	localparam int STAT_W      = 3;
	localparam int DEPTH_W     = 8;
	localparam int DIV_STEPS   = DATA_W;
	localparam int ITER_W      = $clog2(DIV_STEPS);
	localparam int UPC_W       = 5;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_MUL    = 3'd3,
		OP_DIV    = 3'd4,
		OP_FINISH = 3'd5
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_FEW      = 3'd2,
		ST_DIVZERO  = 3'd3,
		ST_INVALID  = 3'd4,
		ST_NORESULT = 3'd5
	} status_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic {
		RD_TOP,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		ALU_NONE,
		ALU_ADDSUB,
		ALU_MUL_PROD,
		ALU_MUL_CLAMP,
		ALU_DIV_INIT,
		ALU_DIV_STEP,
		ALU_DIV_CLAMP
	} alu_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_PUSH,
		WR_RESULT
	} wr_op_t;

	typedef enum logic [3:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_FULL,
		JC_FEW,
		JC_EMPTY,
		JC_BZERO,
		JC_OVF,
		JC_MORE,
		JC_IS_MUL,
		JC_IS_DIV
	} jcond_t;

	typedef struct packed {
		rd_sel_t rd;
		logic    ld_b;
		logic    ld_a;
		alu_op_t alu;
		wr_op_t  wr;
		logic    cnt_clr;
		logic    done;
		status_t status;
		logic    res_valid;
		jcond_t  jc;
		upc_t    target;
	} ucw_t;

	typedef struct packed {
		logic full;
		logic few;
		logic empty;
		logic bzero;
		logic ovf;
		logic more;
		logic is_mul;
		logic is_div;
	} dp_flags_t;

	typedef struct packed {
		logic [DATA_W-1:0]  value;
		logic               sat;
		logic [DEPTH_W-1:0] depth;
	} dp_result_t;

endpackage

// ===== hdl/rpn_stack_evaluator_core.sv =====
// Top level of the RPN stack evaluator: sequencer, datapath and output register.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     opcode, operand_value
//  out      source     out_valid / out_stall   status, result_value, result_valid,
//                                              saturated, stack_depth
//
// One transaction at a time; in_stall is high from the cycle after acceptance until the
// result is loaded, then low again before the next acceptance.
// A divide runs the 32-step radix-2 divider loop, which is skipped when the quotient
// overflows; an invalid opcode, a divide by zero or another error ends the token early.
// While out_stall holds a result, the next token runs up to its final step and waits there.
// Reset empties the stack at once; stack entries are never cleared.
`timescale 1ns / 1ps

module rpn_stack_evaluator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rse_pkg::OPC_W-1:0]         opcode,
	input  logic signed [rse_pkg::DATA_W-1:0] operand_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rse_pkg::STAT_W-1:0]        status,
	output logic signed [rse_pkg::DATA_W-1:0] result_value,
	output logic                              result_valid,
	output logic                              saturated,
	output logic [rse_pkg::DEPTH_W-1:0]       stack_depth
);
	import rse_pkg::*;

	logic               accept, busy, out_free;
	ucw_t               ctrl;
	dp_flags_t          flags;
	dp_result_t         res;
	logic               out_valid_q;
	status_t            status_q;
	logic [DATA_W-1:0]  value_q;
	logic               rvalid_q, sat_q;
	logic [DEPTH_W-1:0] depth_q;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;
	assign out_free = !out_valid_q || !out_stall;

	rse_microcode u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	rse_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_load      (accept),
		.opcode        (opcode),
		.operand_value (operand_value),
		.ctrl          (ctrl),
		.flags         (flags),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			status_q <= ctrl.status;
			value_q  <= res.value;
			rvalid_q <= ctrl.res_valid;
			sat_q    <= res.sat;
			depth_q  <= res.depth;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign result_valid = rvalid_q;
	assign saturated    = sat_q;
	assign stack_depth  = depth_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer not busy after accepting a transaction");
`endif

endmodule

// ===== hdl/rse_microcode.sv =====
// Microcode ROM and sequencer: step counter, opcode dispatch and conditional jumps.
`timescale 1ns / 1ps

module rse_microcode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [rse_pkg::OPC_W-1:0] opcode,
	input  logic                      out_free,
	input  rse_pkg::dp_flags_t        flags,
	output rse_pkg::ucw_t             ctrl,
	output logic                      busy
);
	import rse_pkg::*;

	localparam upc_t UA_PUSH     = 5'd0;
	localparam upc_t UA_FINISH   = 5'd2;
	localparam upc_t UA_ARITH    = 5'd4;
	localparam upc_t UA_MUL      = 5'd9;
	localparam upc_t UA_DIV      = 5'd11;
	localparam upc_t UA_DIV_LOOP = 5'd13;
	localparam upc_t UA_DIV_END  = 5'd14;
	localparam upc_t UA_WB       = 5'd15;
	localparam upc_t UA_ERR_FULL = 5'd16;
	localparam upc_t UA_ERR_FEW  = 5'd17;
	localparam upc_t UA_ERR_DIVZ = 5'd18;
	localparam upc_t UA_INVALID  = 5'd19;
	localparam upc_t UA_NORES    = 5'd20;

	function automatic ucw_t rom_word(input upc_t a);
		ucw_t w;
		w = '0;
		case (a)
			UA_PUSH: begin
				w.jc = JC_FULL;
				w.target = UA_ERR_FULL;
			end
			5'd1: begin
				w.wr = WR_PUSH;
				w.done = 1'b1;
				w.status = ST_OK;
			end
			UA_FINISH: begin
				w.rd = RD_TOP;
				w.jc = JC_EMPTY;
				w.target = UA_NORES;
			end
			5'd3: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_OK;
				w.res_valid = 1'b1;
			end
			UA_ARITH: begin
				w.rd = RD_TOP;
				w.jc = JC_FEW;
				w.target = UA_ERR_FEW;
			end
			5'd5: begin
				w.ld_b = 1'b1;
				w.rd = RD_NEXT;
			end
			5'd6: begin
				w.ld_a = 1'b1;
				w.jc = JC_IS_MUL;
				w.target = UA_MUL;
			end
			5'd7: begin
				w.jc = JC_IS_DIV;
				w.target = UA_DIV;
			end
			5'd8: begin
				w.alu = ALU_ADDSUB;
				w.jc = JC_ALWAYS;
				w.target = UA_WB;
			end
			UA_MUL: begin
				w.alu = ALU_MUL_PROD;
			end
			5'd10: begin
				w.alu = ALU_MUL_CLAMP;
				w.jc = JC_ALWAYS;
				w.target = UA_WB;
			end
			UA_DIV: begin
				w.alu = ALU_DIV_INIT;
				w.jc = JC_BZERO;
				w.target = UA_ERR_DIVZ;
			end
			5'd12: begin
				w.jc = JC_OVF;
				w.target = UA_DIV_END;
			end
			UA_DIV_LOOP: begin
				w.alu = ALU_DIV_STEP;
				w.jc = JC_MORE;
				w.target = UA_DIV_LOOP;
			end
			UA_DIV_END: begin
				w.alu = ALU_DIV_CLAMP;
			end
			UA_WB: begin
				w.wr = WR_RESULT;
				w.done = 1'b1;
				w.status = ST_OK;
			end
			UA_ERR_FULL: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_FULL;
			end
			UA_ERR_FEW: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_FEW;
			end
			UA_ERR_DIVZ: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_DIVZERO;
			end
			UA_INVALID: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_INVALID;
			end
			UA_NORES: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_NORESULT;
			end
			default: begin
				w.cnt_clr = 1'b1;
				w.done = 1'b1;
				w.status = ST_INVALID;
			end
		endcase
		return w;
	endfunction

	seq_state_t state_q, state_d;
	upc_t       pc_q, pc_d, entry;
	ucw_t       cw;
	logic       fire, take;

	always_comb begin
		case (opcode)
			OP_PUSH:                        entry = UA_PUSH;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: entry = UA_ARITH;
			OP_FINISH:                      entry = UA_FINISH;
			default:                        entry = UA_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		cw   = rom_word(pc_q);
		fire = (state_q == SEQ_RUN) && (!cw.done || out_free);
		ctrl = fire ? cw : '0;
		busy = (state_q == SEQ_RUN);
		case (cw.jc)
			JC_NEXT:   take = 1'b0;
			JC_ALWAYS: take = 1'b1;
			JC_FULL:   take = flags.full;
			JC_FEW:    take = flags.few;
			JC_EMPTY:  take = flags.empty;
			JC_BZERO:  take = flags.bzero;
			JC_OVF:    take = flags.ovf;
			JC_MORE:   take = flags.more;
			JC_IS_MUL: take = flags.is_mul;
			JC_IS_DIV: take = flags.is_div;
			default:   take = 1'b0;
		endcase
		state_d = state_q;
		pc_d    = pc_q;
		case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					state_d = SEQ_RUN;
					pc_d    = entry;
				end
			end
			SEQ_RUN: begin
				if (fire) begin
					if (cw.done) begin
						state_d = SEQ_IDLE;
					end else begin
						pc_d = take ? cw.target : upc_t'(pc_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rse_datapath.sv =====
// Stack memory, operand registers, saturating add/sub, multiplier and radix-2 divider.
`timescale 1ns / 1ps

module rse_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tok_load,
	input  logic [rse_pkg::OPC_W-1:0]         opcode,
	input  logic signed [rse_pkg::DATA_W-1:0] operand_value,
	input  rse_pkg::ucw_t                     ctrl,
	output rse_pkg::dp_flags_t                flags,
	output rse_pkg::dp_result_t               res
);
	import rse_pkg::*;

	localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic logic [DATA_W:0] clamp_sm(input logic neg,
		input logic [DATA_W+FRAC_W-1:0] mag);
		logic [DATA_W-1:0] r;
		logic              s;
		s = 1'b0;
		if (neg) begin
			if (mag > {{FRAC_W{1'b0}}, Q_MIN}) begin
				s = 1'b1;
				r = Q_MIN;
			end else begin
				r = -mag[DATA_W-1:0];
			end
		end else begin
			if (mag > {{FRAC_W{1'b0}}, Q_MAX}) begin
				s = 1'b1;
				r = Q_MAX;
			end else begin
				r = mag[DATA_W-1:0];
			end
		end
		return {s, r};
	endfunction

	logic [DATA_W-1:0]       mem [STACK_DEPTH];
	logic [CW-1:0]           count_q, count_d, cnt_m1, cnt_m2;
	logic [AW-1:0]           raddr;
	logic [DATA_W-1:0]       rdata_q, rd_mag;
	opcode_t                 op_q;
	logic [DATA_W-1:0]       val_q;
	logic [DATA_W-1:0]       a_q, b_q, ma_q, mb_q;
	logic [2*DATA_W-1:0]     prod_q;
	logic [DATA_W-1:0]       rem_q, dvd_q;
	logic [ITER_W-1:0]       iter_q;
	logic                    ovf_q;
	logic [DATA_W-1:0]       r_q;
	logic                    sat_q;
	logic                    neg, sum_ovf, div_ge;
	logic [DATA_W:0]         sum, div_t, div_diff, clamp_mul, clamp_div;
	logic [CW+DEPTH_W-1:0]   depth_ext;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign raddr  = (ctrl.rd == RD_NEXT) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
	assign rd_mag = rdata_q[DATA_W-1] ? -rdata_q : rdata_q;
	assign neg    = a_q[DATA_W-1] ^ b_q[DATA_W-1];

	always_comb begin
		if (op_q == OP_SUB) begin
			sum = {a_q[DATA_W-1], a_q} - {b_q[DATA_W-1], b_q};
		end else begin
			sum = {a_q[DATA_W-1], a_q} + {b_q[DATA_W-1], b_q};
		end
		sum_ovf   = sum[DATA_W] ^ sum[DATA_W-1];
		div_t     = {rem_q, dvd_q[DATA_W-1]};
		div_diff  = div_t - {1'b0, mb_q};
		div_ge    = !div_diff[DATA_W] || div_t[DATA_W];
		clamp_mul = clamp_sm(neg, prod_q[2*DATA_W-1:FRAC_W]);
		clamp_div = clamp_sm(neg, ovf_q ? {{(FRAC_W-1){1'b0}}, 1'b1, {DATA_W{1'b0}}}
			: {{FRAC_W{1'b0}}, dvd_q});
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.cnt_clr) begin
			count_d = '0;
		end else begin
			case (ctrl.wr)
				WR_PUSH:   count_d = count_q + CW'(1);
				WR_RESULT: count_d = cnt_m1;
				default:   count_d = count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (tok_load) begin
				sat_q <= 1'b0;
			end else begin
				case (ctrl.alu)
					ALU_ADDSUB:    sat_q <= sum_ovf;
					ALU_MUL_CLAMP: sat_q <= clamp_mul[DATA_W];
					ALU_DIV_CLAMP: sat_q <= clamp_div[DATA_W];
					default:       sat_q <= sat_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		case (ctrl.wr)
			WR_PUSH:   mem[count_q[AW-1:0]] <= val_q;
			WR_RESULT: mem[cnt_m2[AW-1:0]]  <= r_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tok_load) begin
			op_q  <= opcode_t'(opcode);
			val_q <= operand_value;
		end
		if (ctrl.ld_b) begin
			b_q  <= rdata_q;
			mb_q <= rd_mag;
		end
		if (ctrl.ld_a) begin
			a_q  <= rdata_q;
			ma_q <= rd_mag;
		end
		case (ctrl.alu)
			ALU_ADDSUB: begin
				if (sum_ovf) begin
					r_q <= sum[DATA_W] ? Q_MIN : Q_MAX;
				end else begin
					r_q <= sum[DATA_W-1:0];
				end
			end
			ALU_MUL_PROD: begin
				prod_q <= ma_q * mb_q;
			end
			ALU_MUL_CLAMP: begin
				r_q <= clamp_mul[DATA_W-1:0];
			end
			ALU_DIV_INIT: begin
				rem_q  <= {{(DATA_W-FRAC_W){1'b0}}, ma_q[DATA_W-1:FRAC_W]};
				dvd_q  <= {ma_q[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
				iter_q <= ITER_W'(DIV_STEPS - 1);
				ovf_q  <= ({{(DATA_W-FRAC_W){1'b0}}, ma_q[DATA_W-1:FRAC_W]} >= mb_q);
			end
			ALU_DIV_STEP: begin
				rem_q  <= div_ge ? div_diff[DATA_W-1:0] : div_t[DATA_W-1:0];
				dvd_q  <= {dvd_q[DATA_W-2:0], div_ge};
				iter_q <= iter_q - ITER_W'(1);
			end
			ALU_DIV_CLAMP: begin
				r_q <= clamp_div[DATA_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign flags.full   = (count_q >= CW'(STACK_DEPTH));
	assign flags.few    = (count_q < CW'(2));
	assign flags.empty  = (count_q == '0);
	assign flags.bzero  = (b_q == '0);
	assign flags.ovf    = ovf_q;
	assign flags.more   = (iter_q != '0);
	assign flags.is_mul = (op_q == OP_MUL);
	assign flags.is_div = (op_q == OP_DIV);

	assign depth_ext = {{DEPTH_W{1'b0}}, count_d};
	assign res.value = ctrl.res_valid ? rdata_q : '0;
	assign res.sat   = sat_q;
	assign res.depth = depth_ext[DEPTH_W-1:0];

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr == WR_PUSH |-> count_q < CW'(STACK_DEPTH))
		else $error("push write on a full stack");
	a_wb_operands: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr == WR_RESULT |-> count_q >= CW'(2))
		else $error("result write-back without two operands");
`endif

endmodule
